### hw/rtl/dbps_pkg.sv
// Shared types, constants and result builders for the data block page segmenter.
`default_nettype none

package dbps_pkg;

	localparam int HEADER_BYTES  = 64;
	localparam int UNPAGED_LIMIT = 65472;

	localparam logic [15:0] HDR_LEN   = 16'(HEADER_BYTES);
	localparam logic [15:0] UNP_LIMIT = 16'(UNPAGED_LIMIT);

	localparam int SLOTS = 4;
	localparam int SLOT_W = $clog2(SLOTS);

	// result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_BYTE   = 2'd1;
	localparam logic [1:0] KIND_PAD    = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	// input item types
	localparam logic REQ_HEADER  = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	// register indexes
	localparam logic REG_PAGE_SIZE = 1'b0;
	localparam logic REG_PADDING   = 1'b1;

	localparam logic [15:0] PAGE_SIZE_RESET = 16'd8192;
	localparam logic [7:0]  PADDING_RESET   = 8'd0;

	typedef struct packed {
		logic [15:0] page_size;
		logic [7:0]  padding_byte;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] hdr_orbit;
		logic [11:0] hdr_bunch_crossing;
		logic [15:0] hdr_source_id;
		logic [15:0] offset_to_next;
		logic [15:0] page_counter;
		logic [15:0] memory_size;
		logic        stop_bit;
		logic [7:0]  out_byte;
		logic [15:0] pad_length;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [SLOT_W:0]          count;
		res_t [SLOTS-1:0]         slot;
	} bundle_t;

	function automatic res_t mk_hdr(input logic [31:0] orbit, input logic [11:0] bc,
			input logic [15:0] sid, input logic [15:0] cnt, input logic [15:0] mem,
			input logic [15:0] off, input logic stop, input logic last);
		res_t r;
		r = '0;
		r.kind = KIND_HEADER;
		r.hdr_orbit = orbit;
		r.hdr_bunch_crossing = bc;
		r.hdr_source_id = sid;
		r.offset_to_next = off;
		r.page_counter = cnt;
		r.memory_size = mem;
		r.stop_bit = stop;
		r.last = last;
		return r;
	endfunction

	function automatic res_t mk_pad(input logic [7:0] pb, input logic [15:0] len,
			input logic last);
		res_t r;
		r = '0;
		r.kind = KIND_PAD;
		r.out_byte = pb;
		r.pad_length = len;
		r.last = last;
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/dbps_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface dbps_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] orbit;
	logic [11:0] bunch_crossing;
	logic [15:0] source_id;
	logic [15:0] payload_size;
	logic [7:0]  in_byte;

	modport source (output valid, req_type, orbit, bunch_crossing, source_id,
		payload_size, in_byte, input ready);
	modport sink (input valid, req_type, orbit, bunch_crossing, source_id,
		payload_size, in_byte, output ready);
endinterface

interface dbps_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] hdr_orbit;
	logic [11:0] hdr_bunch_crossing;
	logic [15:0] hdr_source_id;
	logic [15:0] offset_to_next;
	logic [15:0] page_counter;
	logic [15:0] memory_size;
	logic        stop_bit;
	logic [7:0]  out_byte;
	logic [15:0] pad_length;
	logic        last;

	modport source (output valid, kind, hdr_orbit, hdr_bunch_crossing, hdr_source_id,
		offset_to_next, page_counter, memory_size, stop_bit, out_byte, pad_length,
		last, input ready);
	modport sink (input valid, kind, hdr_orbit, hdr_bunch_crossing, hdr_source_id,
		offset_to_next, page_counter, memory_size, stop_bit, out_byte, pad_length,
		last, output ready);
endinterface

`default_nettype wire

### hw/rtl/dbps_regs.sv
// APB configuration registers: page size and padding byte.
`default_nettype none

module dbps_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output dbps_pkg::cfg_t     cfg
);
	import dbps_pkg::*;

	logic [15:0] page_size_q;
	logic [7:0]  padding_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= PAGE_SIZE_RESET;
			padding_q <= PADDING_RESET;
		end else if (wr) begin
			unique case (paddr[2])
				REG_PAGE_SIZE: page_size_q <= pwdata[15:0];
				REG_PADDING:   padding_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PAGE_SIZE: prdata = {16'd0, page_size_q};
			REG_PADDING:   prdata = {24'd0, padding_q};
			default:       prdata = '0;
		endcase
	end

	assign cfg.page_size = page_size_q;
	assign cfg.padding_byte = padding_q;
endmodule

`default_nettype wire

### hw/rtl/dbps_core.sv
// Block state and page arithmetic: turns one accepted item into a bundle of results.
`default_nettype none

module dbps_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic           req_type,
	input  wire logic [31:0]    orbit,
	input  wire logic [11:0]    bunch_crossing,
	input  wire logic [15:0]    source_id,
	input  wire logic [15:0]    payload_size,
	input  wire logic [7:0]     in_byte,
	input  wire dbps_pkg::cfg_t cfg,
	output dbps_pkg::bundle_t   bundle
);
	import dbps_pkg::*;

	logic [31:0] orbit_q;
	logic [11:0] bc_q;
	logic [15:0] sid_q;
	logic [15:0] remain_q;
	logic [15:0] fill_q;
	logic [15:0] index_q;
	logic        discard_q;

	logic [31:0] orbit_d;
	logic [11:0] bc_d;
	logic [15:0] sid_d;
	logic [15:0] remain_d;
	logic [15:0] fill_d;
	logic [15:0] index_d;
	logic        discard_d;

	logic [15:0] ps;
	logic [15:0] usable;
	logic        paged;
	logic        bad_ps;
	logic [15:0] first_len;
	logic [15:0] rem1;
	logic [15:0] fill1;
	logic [15:0] idx1;
	logic [15:0] next_len;
	logic [SLOT_W:0] n;

	assign ps = cfg.page_size;
	assign usable = ps - HDR_LEN;
	assign paged = ps > HDR_LEN;
	assign bad_ps = (ps != 16'd0) && !paged;
	assign first_len = (payload_size < usable) ? payload_size : usable;
	assign rem1 = remain_q - 16'd1;
	assign fill1 = fill_q + 16'd1;
	assign idx1 = index_q + 16'd1;
	assign next_len = (rem1 < usable) ? rem1 : usable;

	always_comb begin
		orbit_d = orbit_q;
		bc_d = bc_q;
		sid_d = sid_q;
		remain_d = remain_q;
		fill_d = fill_q;
		index_d = index_q;
		discard_d = discard_q;
		bundle = '0;
		n = '0;

		if (req_type == REQ_HEADER) begin
			orbit_d = orbit;
			bc_d = bunch_crossing;
			sid_d = source_id;
			remain_d = payload_size;
			fill_d = '0;
			index_d = '0;
			discard_d = 1'b0;
			if ((ps == 16'd0 && payload_size > UNP_LIMIT) || bad_ps) begin
				bundle.slot[0] = '0;
				bundle.slot[0].kind = KIND_ERROR;
				bundle.slot[0].hdr_orbit = orbit;
				bundle.slot[0].hdr_bunch_crossing = bunch_crossing;
				bundle.slot[0].hdr_source_id = source_id;
				bundle.slot[0].last = 1'b1;
				discard_d = payload_size != 16'd0;
				bundle.count = 3'd1;
			end else if (ps == 16'd0) begin
				bundle.slot[0] = mk_hdr(orbit, bunch_crossing, source_id, 16'd0,
					payload_size + HDR_LEN, payload_size + HDR_LEN, 1'b0, 1'b0);
				bundle.count = 3'd1;
				if (payload_size == 16'd0) begin
					bundle.slot[1] = mk_hdr(orbit, bunch_crossing, source_id, 16'd1,
						HDR_LEN, HDR_LEN, 1'b1, 1'b1);
					bundle.count = 3'd2;
				end
			end else begin
				bundle.slot[0] = mk_hdr(orbit, bunch_crossing, source_id, 16'd0,
					first_len + HDR_LEN, ps, 1'b0, 1'b0);
				bundle.count = 3'd1;
				if (payload_size == 16'd0) begin
					bundle.slot[1] = mk_pad(cfg.padding_byte, usable, 1'b0);
					bundle.slot[2] = mk_hdr(orbit, bunch_crossing, source_id, 16'd1,
						HDR_LEN, ps, 1'b1, 1'b0);
					bundle.slot[3] = mk_pad(cfg.padding_byte, usable, 1'b1);
					bundle.count = 3'd4;
				end
			end
		end else if (remain_q != 16'd0) begin
			remain_d = rem1;
			if (discard_q) begin
				discard_d = rem1 != 16'd0;
			end else begin
				bundle.slot[0] = '0;
				bundle.slot[0].kind = KIND_BYTE;
				bundle.slot[0].out_byte = in_byte;
				n = 3'd1;
				fill_d = fill1;
				if (!paged) begin
					// page size dropped mid-block: finish as unpaged
					if (rem1 == 16'd0) begin
						bundle.slot[1] = mk_hdr(orbit_q, bc_q, sid_q, idx1, HDR_LEN,
							HDR_LEN, 1'b1, 1'b1);
						n = 3'd2;
					end
				end else if (fill1 >= usable || rem1 == 16'd0) begin
					if (fill1 < usable) begin
						bundle.slot[n[SLOT_W-1:0]] = mk_pad(cfg.padding_byte,
							usable - fill1, 1'b0);
						n = n + 3'd1;
					end
					index_d = idx1;
					fill_d = '0;
					if (rem1 != 16'd0) begin
						bundle.slot[n[SLOT_W-1:0]] = mk_hdr(orbit_q, bc_q, sid_q, idx1,
							next_len + HDR_LEN, ps, 1'b0, 1'b0);
						n = n + 3'd1;
					end else begin
						bundle.slot[n[SLOT_W-1:0]] = mk_hdr(orbit_q, bc_q, sid_q, idx1,
							HDR_LEN, ps, 1'b1, 1'b0);
						n = n + 3'd1;
						bundle.slot[n[SLOT_W-1:0]] = mk_pad(cfg.padding_byte, usable, 1'b1);
						n = n + 3'd1;
					end
				end
				bundle.count = n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orbit_q <= '0;
			bc_q <= '0;
			sid_q <= '0;
			remain_q <= '0;
			fill_q <= '0;
			index_q <= '0;
			discard_q <= 1'b0;
		end else if (accept) begin
			orbit_q <= orbit_d;
			bc_q <= bc_d;
			sid_q <= sid_d;
			remain_q <= remain_d;
			fill_q <= fill_d;
			index_q <= index_d;
			discard_q <= discard_d;
		end
	end
endmodule

`default_nettype wire

### hw/rtl/dbps_drain.sv
// Result register: holds one bundle and hands its results out one per cycle while the receiver is ready.
`default_nettype none

module dbps_drain (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire dbps_pkg::bundle_t bundle,
	output logic                 free,
	output logic                 valid,
	input  wire logic            ready,
	output dbps_pkg::res_t       res
);
	import dbps_pkg::*;

	res_t [SLOTS-1:0] slot_s1;
	logic [SLOT_W:0]  count_q;
	logic [SLOT_W-1:0] ptr_q;
	logic             take;
	logic             final_take;

	assign valid = count_q != '0;
	assign take = valid && ready;
	assign final_take = take && ({1'b0, ptr_q} == count_q - 3'd1);
	// next transaction may enter as the last result of the bundle leaves
	assign free = !valid || final_take;
	assign res = slot_s1[ptr_q];

	always_ff @(posedge clk) begin
		if (load) slot_s1 <= bundle.slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q <= '0;
		end else if (load) begin
			count_q <= bundle.count;
			ptr_q <= '0;
		end else if (final_take) begin
			count_q <= '0;
			ptr_q <= '0;
		end else if (take) begin
			ptr_q <= ptr_q + 2'd1;
		end
	end
endmodule

`default_nettype wire

### hw/rtl/data_block_page_segmenter.sv
// Top level of the data block page segmenter.
// Input items arrive on the item channel (valid/ready): a block header item
// (orbit, bunch crossing, source id, payload size) followed by the block's
// payload bytes. Results leave on the result channel: page headers, payload
// bytes, padding runs and error items, each with a last flag on a block's end.
// An accepted item updates the block state in the same edge and loads its
// results (zero to four) into the result register; the first result is
// visible in the cycle after acceptance. Payload bytes run at one item per
// cycle while the receiver is ready; an item that closes a page holds the
// input until its results have drained from the single result register,
// which hands them out one a cycle. Stray or discarded bytes give no result.
// A new item is taken in the cycle the last pending result is taken.
// When the receiver stalls, the result holds and the input stops while any
// result of the previous item waits. The APB port sets page size and
// padding byte; write it only while the block is idle. Reset clears the
// block state, page size returns to 8192 and padding byte to 0.
`default_nettype none

module data_block_page_segmenter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	dbps_in_if.sink          item,
	dbps_out_if.source       result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import dbps_pkg::*;

	cfg_t    cfg;
	bundle_t bundle;
	res_t    res;
	logic    free;
	logic    accept;
	logic    load;

	assign item.ready = free;
	assign accept = item.valid && free;
	assign load = accept && (bundle.count != '0);

	dbps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dbps_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.req_type       (item.req_type),
		.orbit          (item.orbit),
		.bunch_crossing (item.bunch_crossing),
		.source_id      (item.source_id),
		.payload_size   (item.payload_size),
		.in_byte        (item.in_byte),
		.cfg            (cfg),
		.bundle         (bundle)
	);

	dbps_drain u_drain (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.bundle (bundle),
		.free   (free),
		.valid  (result.valid),
		.ready  (result.ready),
		.res    (res)
	);

	assign result.kind = res.kind;
	assign result.hdr_orbit = res.hdr_orbit;
	assign result.hdr_bunch_crossing = res.hdr_bunch_crossing;
	assign result.hdr_source_id = res.hdr_source_id;
	assign result.offset_to_next = res.offset_to_next;
	assign result.page_counter = res.page_counter;
	assign result.memory_size = res.memory_size;
	assign result.stop_bit = res.stop_bit;
	assign result.out_byte = res.out_byte;
	assign result.pad_length = res.pad_length;
	assign result.last = res.last;
endmodule

`default_nettype wire

### tb/tb_data_block_page_segmenter.sv
// Self-checking testbench for the data block page segmenter: random blocks, pages and stalls.
`default_nettype none

module tb_data_block_page_segmenter;
	timeunit 1ns;
	timeprecision 1ps;

	import dbps_pkg::*;

	localparam logic [2:0] ADDR_PAGE_SIZE = {REG_PAGE_SIZE, 2'b00};
	localparam logic [2:0] ADDR_PADDING   = {REG_PADDING, 2'b00};
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int ITEM_TARGET   = 420;

	typedef struct packed {
		logic        req_type;
		logic [31:0] orbit;
		logic [11:0] bunch_crossing;
		logic [15:0] source_id;
		logic [15:0] payload_size;
		logic [7:0]  in_byte;
	} blk_item_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	dbps_in_if  item_ch();
	dbps_out_if result_ch();

	data_block_page_segmenter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// register copy and block state of the predictor
	logic [15:0] cfg_page_size = PAGE_SIZE_RESET;
	logic [7:0]  cfg_padding   = PADDING_RESET;
	logic [31:0] blk_orbit   = '0;
	logic [11:0] blk_bc      = '0;
	logic [15:0] blk_sid     = '0;
	logic [15:0] bytes_left  = '0;
	logic [15:0] fill        = '0;
	logic [15:0] pages_done  = '0;
	logic        dropping    = 1'b0;

	blk_item_t items_to_send[$];
	res_t      segments_due[$];
	blk_item_t cur_item;
	res_t      want, seen;

	int items_queued = 0;
	int items_taken = 0;
	int segments_seen = 0;
	int mismatches = 0;
	int settings_used = 0;
	int tx_gap = 0, rx_stall = 0;
	int tx_idle_pct = 0, rx_idle_pct = 0;
	int carry = 0;
	bit quiet = 1'b0;
	bit long_hold_req = 1'b0;

	function automatic res_t page_hdr(input logic [15:0] cnt, input logic [15:0] mem,
			input logic [15:0] off, input logic stop, input logic fin);
		res_t r;
		r = '0;
		r.kind = KIND_HEADER;
		r.hdr_orbit = blk_orbit;
		r.hdr_bunch_crossing = blk_bc;
		r.hdr_source_id = blk_sid;
		r.page_counter = cnt;
		r.memory_size = mem;
		r.offset_to_next = off;
		r.stop_bit = stop;
		r.last = fin;
		return r;
	endfunction

	function automatic res_t pad_run(input logic [15:0] len, input logic fin);
		res_t r;
		r = '0;
		r.kind = KIND_PAD;
		r.out_byte = cfg_padding;
		r.pad_length = len;
		r.last = fin;
		return r;
	endfunction

	// works out the results of one accepted item and updates the block state
	task automatic segment_item(input blk_item_t it);
		logic [15:0] u, len, p;
		res_t r;
		p = it.payload_size;
		u = cfg_page_size - HDR_LEN;
		if (it.req_type == REQ_HEADER) begin
			blk_orbit = it.orbit;
			blk_bc = it.bunch_crossing;
			blk_sid = it.source_id;
			bytes_left = p;
			fill = '0;
			pages_done = '0;
			dropping = 1'b0;
			if ((cfg_page_size == 0 && p > UNP_LIMIT) ||
					(cfg_page_size != 0 && cfg_page_size <= HDR_LEN)) begin
				r = '0;
				r.kind = KIND_ERROR;
				r.hdr_orbit = blk_orbit;
				r.hdr_bunch_crossing = blk_bc;
				r.hdr_source_id = blk_sid;
				r.last = 1'b1;
				segments_due.push_back(r);
				dropping = (p != 0);
			end else if (cfg_page_size == 0) begin
				segments_due.push_back(page_hdr(16'd0, p + HDR_LEN, p + HDR_LEN, 1'b0, 1'b0));
				if (p == 0)
					segments_due.push_back(page_hdr(16'd1, HDR_LEN, HDR_LEN, 1'b1, 1'b1));
			end else begin
				len = (p < u) ? p : u;
				segments_due.push_back(page_hdr(16'd0, len + HDR_LEN, cfg_page_size, 1'b0, 1'b0));
				if (p == 0) begin
					segments_due.push_back(pad_run(u, 1'b0));
					segments_due.push_back(page_hdr(16'd1, HDR_LEN, cfg_page_size, 1'b1, 1'b0));
					segments_due.push_back(pad_run(u, 1'b1));
				end
			end
		end else if (bytes_left != 0) begin
			bytes_left = bytes_left - 16'd1;
			if (dropping) begin
				if (bytes_left == 0)
					dropping = 1'b0;
			end else begin
				r = '0;
				r.kind = KIND_BYTE;
				r.out_byte = it.in_byte;
				segments_due.push_back(r);
				fill = fill + 16'd1;
				if (cfg_page_size == 0 || cfg_page_size <= HDR_LEN) begin
					// unpaged, possibly after a page size change inside the block
					if (bytes_left == 0)
						segments_due.push_back(page_hdr(pages_done + 16'd1, HDR_LEN, HDR_LEN,
							1'b1, 1'b1));
				end else if (fill >= u || bytes_left == 0) begin
					if (fill < u)
						segments_due.push_back(pad_run(u - fill, 1'b0));
					pages_done = pages_done + 16'd1;
					fill = '0;
					if (bytes_left > 0) begin
						len = (bytes_left < u) ? bytes_left : u;
						segments_due.push_back(page_hdr(pages_done, len + HDR_LEN, cfg_page_size,
							1'b0, 1'b0));
					end else begin
						segments_due.push_back(page_hdr(pages_done, HDR_LEN, cfg_page_size,
							1'b1, 1'b0));
						segments_due.push_back(pad_run(u, 1'b1));
					end
				end
			end
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.req_type <= REQ_HEADER;
			item_ch.orbit <= '0;
			item_ch.bunch_crossing <= '0;
			item_ch.source_id <= '0;
			item_ch.payload_size <= '0;
			item_ch.in_byte <= '0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				segment_item(cur_item);
				items_taken++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (tx_gap > 0 && !quiet) begin
					tx_gap--;
					item_ch.valid <= 1'b0;
				end else if (items_to_send.size() > 0) begin
					cur_item = items_to_send.pop_front();
					item_ch.req_type <= cur_item.req_type;
					item_ch.orbit <= cur_item.orbit;
					item_ch.bunch_crossing <= cur_item.bunch_crossing;
					item_ch.source_id <= cur_item.source_id;
					item_ch.payload_size <= cur_item.payload_size;
					item_ch.in_byte <= cur_item.in_byte;
					item_ch.valid <= 1'b1;
					if (!quiet && $urandom_range(0, 99) < tx_idle_pct)
						tx_gap = $urandom_range(1, 17);
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			mismatches++;
		end
	endtask

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				segments_seen++;
				seen.kind = result_ch.kind;
				seen.hdr_orbit = result_ch.hdr_orbit;
				seen.hdr_bunch_crossing = result_ch.hdr_bunch_crossing;
				seen.hdr_source_id = result_ch.hdr_source_id;
				seen.offset_to_next = result_ch.offset_to_next;
				seen.page_counter = result_ch.page_counter;
				seen.memory_size = result_ch.memory_size;
				seen.stop_bit = result_ch.stop_bit;
				seen.out_byte = result_ch.out_byte;
				seen.pad_length = result_ch.pad_length;
				seen.last = result_ch.last;
				if (segments_due.size() == 0) begin
					$error("unexpected result transaction, kind %0d", seen.kind);
					mismatches++;
				end else begin
					want = segments_due.pop_front();
					check_field("kind", 32'(want.kind), 32'(seen.kind));
					check_field("hdr_orbit", want.hdr_orbit, seen.hdr_orbit);
					check_field("hdr_bunch_crossing", 32'(want.hdr_bunch_crossing),
						32'(seen.hdr_bunch_crossing));
					check_field("hdr_source_id", 32'(want.hdr_source_id),
						32'(seen.hdr_source_id));
					check_field("offset_to_next", 32'(want.offset_to_next),
						32'(seen.offset_to_next));
					check_field("page_counter", 32'(want.page_counter),
						32'(seen.page_counter));
					check_field("memory_size", 32'(want.memory_size), 32'(seen.memory_size));
					check_field("stop_bit", 32'(want.stop_bit), 32'(seen.stop_bit));
					check_field("out_byte", 32'(want.out_byte), 32'(seen.out_byte));
					check_field("pad_length", 32'(want.pad_length), 32'(seen.pad_length));
					check_field("last", 32'(want.last), 32'(seen.last));
				end
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				rx_stall = LONG_HOLD;
			end
			if (rx_stall > 0 && !quiet) begin
				rx_stall--;
				result_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
				rx_stall = $urandom_range(0, 16);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_PAGE_SIZE) begin
			cfg_page_size = data[15:0];
			settings_used++;
		end else begin
			cfg_padding = data[7:0];
		end
	endtask

	task automatic queue_item(input logic req, input logic [31:0] orbit, input logic [11:0] bc,
			input logic [15:0] sid, input logic [15:0] psize, input logic [7:0] data);
		blk_item_t it;
		it.req_type = req;
		it.orbit = orbit;
		it.bunch_crossing = bc;
		it.source_id = sid;
		it.payload_size = psize;
		it.in_byte = data;
		items_to_send.push_back(it);
		items_queued++;
	endtask

	task automatic queue_header(input logic [15:0] psize);
		queue_item(REQ_HEADER, $urandom, 12'($urandom), 16'($urandom), psize, 8'($urandom));
	endtask

	// payload bytes; header fields carry noise that the block must ignore
	task automatic queue_bytes(input int n);
		repeat (n)
			queue_item(REQ_PAYLOAD, $urandom, 12'($urandom), 16'($urandom), 16'($urandom),
				8'($urandom));
	endtask

	// waits until nothing is in flight, then lets the block settle
	task automatic drain();
		do @(negedge clk);
		while (items_to_send.size() != 0 || item_ch.valid || segments_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_phase(input int target, input bit allow_split);
		int start, p, pick;
		int nb;
		start = items_queued;
		if (carry > 0) begin
			queue_bytes(carry);
			carry = 0;
		end
		while (items_queued - start < target) begin
			pick = $urandom_range(0, 99);
			p = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 150) : $urandom_range(0, 40);
			if (pick == 99) begin
				// huge block cut short by the next header
				queue_header(16'($urandom_range(65400, 65535)));
				queue_bytes($urandom_range(0, 5));
			end else if (pick < 8) begin
				queue_header(16'(p));
				queue_bytes($urandom_range(0, p));
			end else begin
				queue_header(16'(p));
				queue_bytes(p);
				if (pick < 14)
					queue_bytes($urandom_range(1, 3));
			end
		end
		// leave a block open across the next register change
		if (allow_split && $urandom_range(0, 2) == 0) begin
			p = $urandom_range(4, 40);
			queue_header(16'(p));
			nb = $urandom_range(1, p - 1);
			queue_bytes(nb);
			carry = p - nb;
		end
	endtask

	initial begin
		int sel;
		logic [15:0] ps;
		int pct[4];
		pct = '{0, 5, 15, 30};
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: empty block, field extremes, stray byte
		queue_item(REQ_HEADER, '0, '0, '0, 16'd0, 8'h00);
		queue_item(REQ_HEADER, '1, '1, '1, 16'd2, 8'hff);
		queue_item(REQ_PAYLOAD, '1, '1, '1, '1, 8'h00);
		queue_item(REQ_PAYLOAD, '0, '0, '0, '0, 8'hff);
		queue_bytes(1);
		drain();
		// smallest usable page: every byte closes a page
		reg_write(ADDR_PAGE_SIZE, 32'(HEADER_BYTES + 1));
		reg_write(ADDR_PADDING, 32'hff);
		queue_header(16'd3);
		queue_bytes(3);
		drain();
		// unpaged: empty, at the limit (size wraps), abandoned, oversized with discard
		reg_write(ADDR_PAGE_SIZE, 32'd0);
		queue_header(16'd0);
		queue_header(UNP_LIMIT);
		queue_bytes(2);
		queue_header(16'd1);
		queue_bytes(1);
		queue_header(UNP_LIMIT + 16'd1);
		queue_bytes(2);
		queue_header(16'd0);
		drain();
		// page size no larger than the header
		reg_write(ADDR_PAGE_SIZE, 32'(HEADER_BYTES));
		queue_header(16'd1);
		queue_bytes(1);
		drain();
		// largest page, then a page size change in the middle of a block
		reg_write(ADDR_PAGE_SIZE, 32'hffff);
		queue_header(16'hffff);
		queue_header(16'd3);
		queue_bytes(1);
		drain();
		reg_write(ADDR_PAGE_SIZE, 32'd0);
		queue_bytes(2);
		drain();

		while (items_queued < ITEM_TARGET - 50) begin
			sel = $urandom_range(0, 9);
			case (sel)
				0: ps = 16'd0;
				1: ps = 16'($urandom_range(1, HEADER_BYTES));
				2: ps = 16'(HEADER_BYTES + 1);
				3: ps = 16'($urandom_range(100, 65535));
				default: ps = 16'($urandom_range(HEADER_BYTES + 2, HEADER_BYTES + 46));
			endcase
			reg_write(ADDR_PAGE_SIZE, 32'(ps));
			reg_write(ADDR_PADDING, $urandom_range(0, 255));
			tx_idle_pct = pct[$urandom_range(0, 3)];
			rx_idle_pct = pct[$urandom_range(0, 3)];
			random_phase(50, 1'b1);
			if (settings_used == 7)
				long_hold_req = 1'b1;
			drain();
		end

		// closing stretch at full rate on both sides
		quiet = 1'b1;
		reg_write(ADDR_PAGE_SIZE, 32'(HEADER_BYTES + 20));
		reg_write(ADDR_PADDING, 32'h5a);
		random_phase(50, 1'b0);
		drain();

		$display("%0d input items, %0d results checked, %0d page size settings",
			items_taken, segments_seen, settings_used);
		$display("Paged, unpaged, error, empty and abandoned blocks, stray bytes, %0d-cycle hold",
			LONG_HOLD);
		if (mismatches == 0 && segments_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
